// File: sv/mtks_pkg.sv
// Shared types and constants for the multiplexed touch key scanner.
// No dependencies; every other file in the block imports this package.
package mtks_pkg;

    localparam int KEYS_PER_GROUP = 16;
    localparam int CH_W           = 4;
    localparam int RAW_W          = 16;
    localparam int CFG_DATA_W     = 16;
    localparam int NG_W           = 3;
    localparam int EKEY_W         = 6;
    localparam int GSEL_W         = 2;
    localparam int ENTRY_W        = 2 * KEYS_PER_GROUP;

    // Item operation codes
    typedef enum logic
    {
        OP_SAMPLE = 1'b0,
        OP_POP    = 1'b1
    } op_t;

    // Configuration register indexes
    typedef enum logic
    {
        CFG_THRESHOLD  = 1'b0,
        CFG_NUM_GROUPS = 1'b1
    } cfg_idx_t;

    // One change event as held in the event store
    typedef struct packed
    {
        logic [EKEY_W-1:0] key;
        logic              value;
    } event_t;

    // Item held between the front stage and the update stage
    typedef struct packed
    {
        logic              pop;
        logic              done;
        logic              touched;
        logic [CH_W-1:0]   ch;
        logic [EKEY_W-1:0] key;
        logic [CH_W-1:0]   mux_select;
        logic [GSEL_W-1:0] group_select;
    } item_t;

    // Key state change found by the bitmap update
    typedef struct packed
    {
        logic   change;
        event_t evt;
    } change_t;

    // Result of a pop
    typedef struct packed
    {
        logic   valid;
        event_t evt;
    } pop_t;

endpackage

// File: sv/mtks_scan.sv
// Front stage: sample accumulation, key counter and the stage register.
// Depends on mtks_pkg.
module mtks_scan #(
    parameter int SAMPLES    = 4,
    parameter int MAX_GROUPS = 4
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    accept,
    input  logic                                    advance,
    input  mtks_pkg::op_t                           op,
    input  logic [mtks_pkg::RAW_W-1:0]              raw_sample,
    input  logic [16+$clog2(SAMPLES):0]             lim,
    input  logic [$clog2(MAX_GROUPS+1)-1:0]         ngrp,
    output logic                                    s1_valid,
    output mtks_pkg::item_t                         s1_item,
    output logic [((MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1)-1:0] s1_grp,
    output logic [((MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1)-1:0] rd_grp
);
    import mtks_pkg::*;

    localparam int SUM_W = RAW_W + $clog2(SAMPLES);
    localparam int LIM_W = SUM_W + 1;
    localparam int CNT_W = $clog2(SAMPLES + 1);
    localparam int GW    = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
    localparam int KW    = CH_W + GW;
    localparam int GCW   = $clog2(MAX_GROUPS + 1);
    localparam int CW    = (GCW > GW + 1) ? GCW : GW + 1;

    logic [SUM_W-1:0] sum_reg, sum_next, sum_new;
    logic [CNT_W-1:0] cnt_reg, cnt_next, cnt_inc;
    logic [KW-1:0]    key_reg, key_next, key_cur, key_after, key_post;
    logic [KW:0]      key_inc;
    logic             done, is_sample, out_of_scan, wrap;
    logic             s1_valid_reg, s1_valid_next;
    item_t            s1_item_reg, s1_item_next;
    logic [GW-1:0]    s1_grp_reg, s1_grp_next;

    // Add the reading and find the key that completes
    always_comb
    begin
        is_sample   = (op == OP_SAMPLE);
        sum_new     = sum_reg + SUM_W'(raw_sample);
        cnt_inc     = cnt_reg + CNT_W'(1);
        done        = is_sample && (cnt_inc >= CNT_W'(SAMPLES));
        out_of_scan = CW'(key_reg[KW-1:CH_W]) >= CW'(ngrp);
        key_cur     = out_of_scan ? '0 : key_reg;
        key_inc     = {1'b0, key_cur} + (KW+1)'(1);
        wrap        = CW'(key_inc[KW:CH_W]) >= CW'(ngrp);
        key_after   = wrap ? '0 : key_inc[KW-1:0];
        key_post    = done ? key_after : key_reg;
        rd_grp      = key_cur[KW-1:CH_W];
    end

    // Next values of the scan state
    always_comb
    begin
        sum_next = sum_reg;
        cnt_next = cnt_reg;
        key_next = key_reg;
        if (accept && is_sample)
        begin
            if (done)
            begin
                sum_next = '0;
                cnt_next = '0;
                key_next = key_after;
            end
            else
            begin
                sum_next = sum_new;
                cnt_next = cnt_inc;
            end
        end
    end

    // Build the stage item
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
            s1_valid_next = 1'b1;
        else if (advance)
            s1_valid_next = 1'b0;

        s1_item_next              = s1_item_reg;
        s1_grp_next               = s1_grp_reg;
        if (accept)
        begin
            s1_item_next.pop          = (op == OP_POP);
            s1_item_next.done         = done;
            s1_item_next.touched      = LIM_W'(sum_new) >= lim;
            s1_item_next.ch           = key_cur[CH_W-1:0];
            s1_item_next.key          = EKEY_W'(key_cur);
            s1_item_next.mux_select   = key_post[CH_W-1:0];
            s1_item_next.group_select = GSEL_W'(key_post[KW-1:CH_W]);
            s1_grp_next               = key_cur[KW-1:CH_W];
        end
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg      <= '0;
            cnt_reg      <= '0;
            key_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            sum_reg      <= sum_next;
            cnt_reg      <= cnt_next;
            key_reg      <= key_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    // Hold stage payload
    always_ff @(posedge clk)
    begin
        s1_item_reg <= s1_item_next;
        s1_grp_reg  <= s1_grp_next;
    end

    assign s1_valid = s1_valid_reg;
    assign s1_item  = s1_item_reg;
    assign s1_grp   = s1_grp_reg;

endmodule

// File: sv/mtks_bitmap.sv
// Key bitmap memory: current and previous bitmap of each group, read-modify-write.
// Depends on mtks_pkg.
module mtks_bitmap #(
    parameter int MAX_GROUPS = 4
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    rd_en,
    input  logic [((MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1)-1:0] rd_grp,
    input  logic                                    wr_en,
    input  logic [((MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1)-1:0] grp,
    input  mtks_pkg::item_t                         item,
    output mtks_pkg::change_t                       chg
);
    import mtks_pkg::*;

    logic [ENTRY_W-1:0]        mem [MAX_GROUPS];
    logic [ENTRY_W-1:0]        rd_data_reg;
    logic [ENTRY_W-1:0]        byp_data_reg;
    logic                      rd_ok_reg, rd_ok_next;
    logic                      byp_hit_reg, byp_hit_next;
    logic [MAX_GROUPS-1:0]     ent_valid_reg, ent_valid_next;
    logic [ENTRY_W-1:0]        entry, wr_data;
    logic [KEYS_PER_GROUP-1:0] prev_bits, cur_bits, cur_new;
    logic                      last;

    // Pick the freshest copy of the entry and update it
    always_comb
    begin
        if (byp_hit_reg)
            entry = byp_data_reg;
        else if (rd_ok_reg)
            entry = rd_data_reg;
        else
            entry = '0;

        prev_bits = entry[ENTRY_W-1:KEYS_PER_GROUP];
        cur_bits  = entry[KEYS_PER_GROUP-1:0];
        if (item.ch == '0)
        begin
            prev_bits = cur_bits;
            cur_bits  = '0;
        end
        cur_new    = cur_bits | (KEYS_PER_GROUP'(item.touched) << item.ch);
        last       = prev_bits[item.ch];
        wr_data    = {prev_bits, cur_new};
        chg.change = item.done && (item.touched != last);
        chg.evt    = '{key: item.key, value: item.touched};
    end

    // Track written entries and same-edge write hits
    always_comb
    begin
        ent_valid_next = ent_valid_reg;
        if (wr_en)
            ent_valid_next[grp] = 1'b1;
        rd_ok_next   = rd_ok_reg;
        byp_hit_next = byp_hit_reg;
        if (rd_en)
        begin
            rd_ok_next   = ent_valid_reg[rd_grp];
            byp_hit_next = wr_en && (grp == rd_grp);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ent_valid_reg <= '0;
            rd_ok_reg     <= 1'b0;
            byp_hit_reg   <= 1'b0;
        end
        else
        begin
            ent_valid_reg <= ent_valid_next;
            rd_ok_reg     <= rd_ok_next;
            byp_hit_reg   <= byp_hit_next;
        end
    end

    // Write back and read the memory
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[grp] <= wr_data;
        if (rd_en)
        begin
            rd_data_reg  <= mem[rd_grp];
            byp_data_reg <= wr_data;
        end
    end

    a_wr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (32'(grp) < MAX_GROUPS))
        else $error("bitmap write beyond group count");

    a_bypass_taken: assert property (@(posedge clk) disable iff (!rst_n)
        (rd_en && wr_en && (grp == rd_grp)) |=> byp_hit_reg)
        else $error("same-group write not forwarded");

endmodule

// File: sv/mtks_event_fifo.sv
// Change event ring buffer with one slot kept empty, read with forwarding.
// Depends on mtks_pkg.
module mtks_event_fifo #(
    parameter int FIFO_DEPTH = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              rd_en,
    input  logic              push_en,
    input  mtks_pkg::change_t chg,
    input  logic              pop_en,
    output mtks_pkg::pop_t    pop_res,
    output logic              dropped
);
    import mtks_pkg::*;

    localparam int PTR_W = $clog2(FIFO_DEPTH);

    event_t     mem [FIFO_DEPTH];
    event_t     rd_data_reg, byp_data_reg;
    logic       byp_hit_reg, byp_hit_next;
    logic [PTR_W-1:0] head_reg, head_next, tail_reg, tail_next, head_inc, tail_inc;
    logic       full, empty, do_push, do_pop;

    // Pointer arithmetic and push / pop decisions
    always_comb
    begin
        head_inc  = (head_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : head_reg + PTR_W'(1);
        tail_inc  = (tail_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : tail_reg + PTR_W'(1);
        full      = (tail_inc == head_reg);
        empty     = (head_reg == tail_reg);
        do_push   = push_en && chg.change && !full;
        dropped   = push_en && chg.change && full;
        do_pop    = pop_en && !empty;
        head_next = do_pop ? head_inc : head_reg;
        tail_next = do_push ? tail_inc : tail_reg;
        byp_hit_next = byp_hit_reg;
        if (rd_en)
            byp_hit_next = do_push && (tail_reg == head_next);
    end

    // Drive the pop result, zero when empty
    always_comb
    begin
        pop_res.valid = do_pop;
        if (!do_pop)
            pop_res.evt = '0;
        else if (byp_hit_reg)
            pop_res.evt = byp_data_reg;
        else
            pop_res.evt = rd_data_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg    <= '0;
            tail_reg    <= '0;
            byp_hit_reg <= 1'b0;
        end
        else
        begin
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            byp_hit_reg <= byp_hit_next;
        end
    end

    // Write the pushed beat, read at the next head
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[tail_reg] <= chg.evt;
        if (rd_en)
        begin
            rd_data_reg  <= mem[head_next];
            byp_data_reg <= chg.evt;
        end
    end

    a_no_push_and_pop: assert property (@(posedge clk) disable iff (!rst_n)
        !(do_push && do_pop))
        else $error("push and pop in one cycle");

    a_push_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        do_push |=> (head_reg != tail_reg))
        else $error("buffer empty right after push");

endmodule

// File: sv/mux_touch_key_scanner.sv
// Top level of the multiplexed touch key scanner with its change event buffer.
// Depends on mtks_pkg, mtks_scan, mtks_bitmap and mtks_event_fifo.
//
// Channel   Handshake                Payload
// item      item_valid / item_stall  op, raw_sample
// result    result_valid / result_stall  mux_select, group_select, event_dropped,
//                                    event_valid, event_key, event_value
// cfg       cfg_valid / cfg_ready    cfg_index, cfg_data
//
// One item per cycle while item_stall is low; the edge that takes an item loads
// the front stage register (memory reads issued), and the output register is
// loaded from it when that stage advances.
// Reset needs no clearing pass: group bitmaps carry per-entry valid bits.
// item_stall rises only when the front stage and the output register are both
// full and result_stall is high; cfg_ready is always high.
module mux_touch_key_scanner #(
    parameter int SAMPLES    = 4,
    parameter int FIFO_DEPTH = 16,
    parameter int MAX_GROUPS = 4
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 item_valid,
    output logic                                 item_stall,
    input  mtks_pkg::op_t                        op,
    input  logic [mtks_pkg::RAW_W-1:0]           raw_sample,
    output logic                                 result_valid,
    input  logic                                 result_stall,
    output logic [mtks_pkg::CH_W-1:0]            mux_select,
    output logic [mtks_pkg::GSEL_W-1:0]          group_select,
    output logic                                 event_dropped,
    output logic                                 event_valid,
    output logic [mtks_pkg::EKEY_W-1:0]          event_key,
    output logic                                 event_value,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  mtks_pkg::cfg_idx_t                   cfg_index,
    input  logic [mtks_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import mtks_pkg::*;

    localparam int SUM_W = RAW_W + $clog2(SAMPLES);
    localparam int LIM_W = SUM_W + 1;
    localparam int GW    = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
    localparam int GCW   = $clog2(MAX_GROUPS + 1);

    logic [LIM_W-1:0]  lim_reg, lim_next;
    logic [GCW-1:0]    ngrp_reg, ngrp_next;
    logic [NG_W-1:0]   ng_raw;
    logic              cfg_wr, accept, advance;
    logic              s1_valid;
    item_t             s1_item;
    logic [GW-1:0]     s1_grp, rd_grp;
    change_t           chg;
    pop_t              pop_res;
    logic              dropped;

    logic              out_valid_reg, out_valid_next;
    logic [CH_W-1:0]   mux_reg, mux_next;
    logic [GSEL_W-1:0] grp_sel_reg, grp_sel_next;
    logic              drop_reg, drop_next;
    pop_t              pop_reg, pop_next;

    // Handshake control
    assign advance    = s1_valid && (!out_valid_reg || !result_stall);
    assign item_stall = s1_valid && !advance;
    assign accept     = item_valid && !item_stall;
    assign cfg_ready  = 1'b1;
    assign cfg_wr     = cfg_valid && cfg_ready;

    // Configuration: keep the touch limit as SAMPLES * (threshold + 1)
    always_comb
    begin
        ng_raw    = cfg_data[NG_W-1:0];
        lim_next  = lim_reg;
        ngrp_next = ngrp_reg;
        if (cfg_wr)
        begin
            case (cfg_index)
                CFG_THRESHOLD:
                    lim_next = LIM_W'(SAMPLES) * (LIM_W'(cfg_data) + LIM_W'(1));
                CFG_NUM_GROUPS:
                begin
                    if (ng_raw == '0)
                        ngrp_next = GCW'(1);
                    else if (32'(ng_raw) > MAX_GROUPS)
                        ngrp_next = GCW'(MAX_GROUPS);
                    else
                        ngrp_next = GCW'(ng_raw);
                end
                default:
                    lim_next = lim_reg;
            endcase
        end
    end

    mtks_scan #(
        .SAMPLES    (SAMPLES),
        .MAX_GROUPS (MAX_GROUPS)
    ) u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .advance    (advance),
        .op         (op),
        .raw_sample (raw_sample),
        .lim        (lim_reg),
        .ngrp       (ngrp_reg),
        .s1_valid   (s1_valid),
        .s1_item    (s1_item),
        .s1_grp     (s1_grp),
        .rd_grp     (rd_grp)
    );

    mtks_bitmap #(
        .MAX_GROUPS (MAX_GROUPS)
    ) u_bitmap (
        .clk    (clk),
        .rst_n  (rst_n),
        .rd_en  (accept),
        .rd_grp (rd_grp),
        .wr_en  (advance && s1_item.done),
        .grp    (s1_grp),
        .item   (s1_item),
        .chg    (chg)
    );

    mtks_event_fifo #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .push_en (advance && s1_item.done),
        .chg     (chg),
        .pop_en  (advance && s1_item.pop),
        .pop_res (pop_res),
        .dropped (dropped)
    );

    // Load the output register as the stage advances
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = 1'b1;
        else if (!result_stall)
            out_valid_next = 1'b0;

        mux_next     = mux_reg;
        grp_sel_next = grp_sel_reg;
        drop_next    = drop_reg;
        pop_next     = pop_reg;
        if (advance)
        begin
            mux_next     = s1_item.mux_select;
            grp_sel_next = s1_item.group_select;
            drop_next    = dropped;
            pop_next     = pop_res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lim_reg       <= LIM_W'(SAMPLES);
            ngrp_reg      <= GCW'(1);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            lim_reg       <= lim_next;
            ngrp_reg      <= ngrp_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mux_reg     <= mux_next;
        grp_sel_reg <= grp_sel_next;
        drop_reg    <= drop_next;
        pop_reg     <= pop_next;
    end

    assign result_valid  = out_valid_reg;
    assign mux_select    = mux_reg;
    assign group_select  = grp_sel_reg;
    assign event_dropped = drop_reg;
    assign event_valid   = pop_reg.valid;
    assign event_key     = pop_reg.evt.key;
    assign event_value   = pop_reg.evt.value;

    a_stall_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> (out_valid_reg && s1_valid))
        else $error("item stalled with room in the pipeline");

endmodule
